// ===== rtl/awc_pkg.sv =====
package awc_pkg;

   // actuator count and derived widths
   localparam int NUM_OUTPUTS = 3;
   localparam int IDX_W       = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
   localparam int TGT_W       = 3;
   localparam int CMP_W       = (IDX_W > TGT_W) ? IDX_W : TGT_W;
   localparam int MASK_W      = (NUM_OUTPUTS > 3) ? NUM_OUTPUTS : 3;

   // field widths
   localparam int ACTION_W  = 3;
   localparam int TIME_W    = 32;
   localparam int PERIOD_W  = 16;
   localparam int WIDTH_W   = 2;
   localparam int BTGT_W    = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // command codes
   localparam logic [ACTION_W-1:0] ACT_NONE   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_TOGGLE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_OFF    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_START  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STEP_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BTN_TARGET  = 2'd3;

   // register reset values
   localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd100;
   localparam logic [PERIOD_W-1:0] DEBOUNCE_RST    = 16'd50;
   localparam logic [WIDTH_W-1:0]  WINDOW_RST      = 2'd2;
   localparam logic [BTGT_W-1:0]   BTN_TARGET_RST  = 2'd1;

   // per-poll control broadcast to every cell
   typedef struct packed {
      logic              accept;
      logic              step;
      logic              btn_toggle;
      logic              cmd_toggle;
      logic              all_off;
      logic [WIDTH_W-1:0] window_width;
      logic [BTGT_W-1:0] btn_target;
      logic [TGT_W-1:0]  cmd_target;
   } awc_ctrl_type;

endpackage

// ===== rtl/awc_cell.sv =====
module awc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [awc_pkg::IDX_W-1:0] cell_index,
   input  awc_pkg::awc_ctrl_type   ctrl,
   input  logic                    tok_prev1,
   input  logic                    tok_prev2,
   output logic                    tok_out,
   output logic                    bit_out
);
   import awc_pkg::*;

   logic bit_ff, bit_in;
   logic tok_ff, tok_in;
   logic [CMP_W-1:0] own_idx;
   logic btn_hit, cmd_hit, win, after_btn, after_cmd;

   assign own_idx = CMP_W'(cell_index);
   assign btn_hit = ctrl.btn_toggle && (CMP_W'(ctrl.btn_target) == own_idx);
   assign cmd_hit = ctrl.cmd_toggle && (CMP_W'(ctrl.cmd_target) == own_idx);

   // window membership: the token sits at most width-1 cells behind
   assign win = (ctrl.window_width >= 2'd1 && tok_ff)
             || (ctrl.window_width >= 2'd2 && tok_prev1)
             || (ctrl.window_width >= 2'd3 && tok_prev2);

   // button toggle, then command, then commutation step
   always_comb begin
      after_btn = bit_ff ^ btn_hit;
      if (cmd_hit) begin
         after_cmd = ~after_btn;
      end else if (ctrl.all_off) begin
         after_cmd = 1'b0;
      end else begin
         after_cmd = after_btn;
      end
      bit_in = ctrl.step ? win : after_cmd;
      tok_in = ctrl.step ? tok_prev1 : tok_ff;
   end

   // cell state, token starts at cell zero
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
         tok_ff <= (cell_index == '0);
      end else if (ctrl.accept) begin
         bit_ff <= bit_in;
         tok_ff <= tok_in;
      end
   end

   assign tok_out = tok_ff;
   assign bit_out = bit_in;

endmodule

// ===== rtl/actuator_window_commutator.sv =====
// Actuator controller with a row of identical cells, one per actuator, each
// holding its energize bit and one bit of the one-hot window-start token that
// moves to the next cell on every commutation step. One poll is accepted per
// clock; its result (on_mask, commutating) appears in the output register on
// the following cycle and the next poll is taken in the same cycle as long as
// that register is free or being drained. The rate is set by the combinational
// update of the cells together with the two 32-bit time differences for the
// button debounce and the step period. Configuration writes are taken every
// cycle and apply to the polls after them.
module actuator_window_commutator (
   input  logic                             clock,
   input  logic                             reset,
   // poll channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: target_index[2:0], button_level[3], now_ms[35:4], zero pad[39:36]
   input  logic [awc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: action[2:0]
   input  logic [awc_pkg::ACTION_W-1:0]     req_tuser,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: on_mask[2:0], commutating[3], zero pad[7:4]
   output logic [awc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [awc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [awc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import awc_pkg::*;

   // configuration registers
   logic [PERIOD_W-1:0] step_period_ff;
   logic [PERIOD_W-1:0] debounce_ff;
   logic [WIDTH_W-1:0]  window_width_ff;
   logic [BTGT_W-1:0]   btn_target_ff;

   // poll state
   logic              enable_ff, enable_in;
   logic [TIME_W-1:0] last_step_ff;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic              prev_raw_ff;
   logic              stable_ff, stable_in;

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [ACTION_W-1:0] action;
   logic [TGT_W-1:0]    target;
   logic                raw;
   logic [TIME_W-1:0]   now;
   logic                accept, level_change, settled, step;
   logic [TIME_W-1:0]   held_time, since_step;
   awc_ctrl_type        ctrl;
   logic [NUM_OUTPUTS-1:0] tok, mask_next;
   logic [MASK_W-1:0]   mask_ext;

   assign action = req_tuser;
   assign target = req_tdata[2:0];
   assign raw    = req_tdata[3];
   assign now    = req_tdata[35:4];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // debounce of the raw button level
   assign level_change   = raw != prev_raw_ff;
   assign change_time_in = level_change ? now : change_time_ff;
   assign held_time      = now - change_time_in;
   assign settled        = (held_time > TIME_W'(debounce_ff)) && (raw != stable_ff);
   assign stable_in      = settled ? raw : stable_ff;

   // command decode and commutation timing
   always_comb begin
      unique case (action)
         ACT_START: enable_in = 1'b1;
         ACT_STOP:  enable_in = 1'b0;
         default:   enable_in = enable_ff;
      endcase
   end
   assign since_step = now - last_step_ff;
   assign step       = enable_in && (since_step >= TIME_W'(step_period_ff));

   always_comb begin
      ctrl.accept       = accept;
      ctrl.step         = step;
      ctrl.btn_toggle   = settled && !raw;
      ctrl.cmd_toggle   = action == ACT_TOGGLE;
      ctrl.all_off      = action == ACT_OFF;
      ctrl.window_width = window_width_ff;
      ctrl.btn_target   = btn_target_ff;
      ctrl.cmd_target   = target;
   end

   // row of actuator cells, token taps wrap around the ring
   for (genvar i = 0; i < NUM_OUTPUTS; i++) begin : g_cell
      localparam int P1 = (i + NUM_OUTPUTS - 1) % NUM_OUTPUTS;
      localparam int P2 = (i + 2 * NUM_OUTPUTS - 2) % NUM_OUTPUTS;
      awc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .ctrl       (ctrl),
         .tok_prev1  (tok[P1]),
         .tok_prev2  (tok[P2]),
         .tok_out    (tok[i]),
         .bit_out    (mask_next[i])
      );
   end

   assign mask_ext = MASK_W'(mask_next);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff  <= STEP_PERIOD_RST;
         debounce_ff     <= DEBOUNCE_RST;
         window_width_ff <= WINDOW_RST;
         btn_target_ff   <= BTN_TARGET_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_STEP_PERIOD: step_period_ff  <= csr_data;
            REG_DEBOUNCE:    debounce_ff     <= csr_data;
            REG_WINDOW:      window_width_ff <= csr_data[WIDTH_W-1:0];
            REG_BTN_TARGET:  btn_target_ff   <= csr_data[BTGT_W-1:0];
            default: ;
         endcase
      end
   end

   // poll state update
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         last_step_ff   <= '0;
         change_time_ff <= '0;
         prev_raw_ff    <= 1'b1;
         stable_ff      <= 1'b1;
      end else if (accept) begin
         enable_ff      <= enable_in;
         change_time_ff <= change_time_in;
         prev_raw_ff    <= raw;
         stable_ff      <= stable_in;
         if (step) begin
            last_step_ff <= now;
         end
      end
   end

   // result register, drained by a transfer on the result channel
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {4'b0000, enable_in, mask_ext[2:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/awc_checker.sv =====
module awc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [awc_pkg::ACTION_W-1:0]     req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [awc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import awc_pkg::*;

   // a held result keeps its value until the transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // every accepted poll yields a result on the next cycle
   a_poll_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted poll gave no result");

   // an empty output register never blocks the poll channel
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("poll channel stalled with empty output");

   // start command shows up as commutating
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ACT_START |=> rsp_tdata[3])
      else $error("start command not reflected");

   // stop command clears commutating
   a_stop: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ACT_STOP |=> !rsp_tdata[3])
      else $error("stop command not reflected");

endmodule

bind actuator_window_commutator awc_checker u_awc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/tb_actuator_window_commutator.sv =====
module tb_actuator_window_commutator;
   timeunit 1ns;
   timeprecision 1ps;

   import awc_pkg::*;

   // action codes the block must ignore
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN_HI = 3'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [TGT_W-1:0]    target;
      logic                level;
      logic [TIME_W-1:0]   now_ms;
      int                  gap;
      bit                  hold;
   } poll_type;

   typedef struct packed {
      logic [2:0] on_mask;
      logic       commutating;
   } status_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [ACTION_W-1:0]   req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   actuator_window_commutator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register copies
   logic [PERIOD_W-1:0] cfg_period;
   logic [PERIOD_W-1:0] cfg_debounce;
   logic [WIDTH_W-1:0]  cfg_width;
   logic [BTGT_W-1:0]   cfg_button;

   // controller state as predicted
   logic [MASK_W-1:0] mask_now;
   logic              commutate_on;
   int                window_head;
   logic [TIME_W-1:0] last_step_ms;
   logic              prev_level;
   logic [TIME_W-1:0] level_edge_ms;
   logic              settled_level;

   poll_type   poll_q[$];
   status_type status_q[$];
   poll_type   live_poll;
   int      polls_queued = 0;
   int      accepted_cnt = 0;
   int      checked_cnt  = 0;
   int      fault_cnt    = 0;
   int      idle_wait    = 0;
   int      stall_left   = 0;
   int      cycle_cnt    = 0;
   bit      gap_calm     = 1'b0;
   bit      ready_calm   = 1'b0;
   logic [TIME_W-1:0] sim_ms = '0;

   task automatic log_fault(input string what);
      fault_cnt++;
      if (fault_cnt <= REPORT_MAX)
         $display("result %0d: %s", checked_cnt, what);
   endtask

   task automatic flip_actuator(input int idx);
      if (idx < NUM_OUTPUTS)
         mask_now[idx] = ~mask_now[idx];
   endtask

   // one poll: debounce and button, then command, then commutation step
   task automatic predict_poll(input poll_type p);
      logic [MASK_W-1:0] win;
      if (p.level != prev_level)
         level_edge_ms = p.now_ms;
      if ((p.now_ms - level_edge_ms) > cfg_debounce && p.level != settled_level) begin
         settled_level = p.level;
         if (!settled_level)
            flip_actuator(cfg_button);
      end
      prev_level = p.level;

      case (p.action)
         ACT_TOGGLE: flip_actuator(p.target);
         ACT_OFF:    mask_now = '0;
         ACT_START:  commutate_on = 1'b1;
         ACT_STOP:   commutate_on = 1'b0;
         default: ;
      endcase

      if (commutate_on && (p.now_ms - last_step_ms) >= cfg_period) begin
         last_step_ms = p.now_ms;
         win = '0;
         for (int j = 0; j < cfg_width; j++)
            win[(window_head + j) % NUM_OUTPUTS] = 1'b1;
         mask_now = win;
         window_head = (window_head + 1) % NUM_OUTPUTS;
      end
      status_q.push_back('{on_mask: mask_now[2:0], commutating: commutate_on});
   endtask

   task automatic queue_poll(input logic [ACTION_W-1:0] act, input logic [TGT_W-1:0] tgt,
                             input logic lvl, input logic [TIME_W-1:0] at_ms,
                             input bit hold);
      poll_type p;
      p.action = act;
      p.target = tgt;
      p.level  = lvl;
      p.now_ms = at_ms;
      p.gap    = gap_calm ? 0 : $urandom_range(0, 13);
      p.hold   = hold;
      poll_q.push_back(p);
      polls_queued++;
   endtask

   // block is idle once every queued poll has its result checked
   task automatic wait_drained();
      do @(posedge clock); while (checked_cnt != polls_queued);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [CSR_DATA_W-1:0] period, debounce,
                             width_word, target_word);
      logic [CSR_IDX_W-1:0]  idx [4];
      logic [CSR_DATA_W-1:0] val [4];
      idx = '{REG_STEP_PERIOD, REG_DEBOUNCE, REG_WINDOW, REG_BTN_TARGET};
      val = '{period, debounce, width_word, target_word};
      for (int r = 0; r < 4; r++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[r];
         csr_data  <= val[r];
         do @(posedge clock); while (!csr_ready);
         case (idx[r])
            REG_STEP_PERIOD: cfg_period   = val[r];
            REG_DEBOUNCE:    cfg_debounce = val[r];
            REG_WINDOW:      cfg_width    = val[r][WIDTH_W-1:0];
            REG_BTN_TARGET:  cfg_button   = val[r][BTGT_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic fill_random(input int count);
      int scale;
      int adv;
      int pick;
      int run_left;
      logic lvl;
      logic raw;
      logic [ACTION_W-1:0] act;
      logic [TGT_W-1:0] tgt;
      scale = (cfg_period > cfg_debounce) ? cfg_period : cfg_debounce;
      if (scale < 8)
         scale = 8;
      lvl = 1'b1;
      run_left = 0;
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0)
            gap_calm = ($urandom_range(0, 3) == 0);
         // button held in runs, with an occasional bounce
         if (run_left == 0) begin
            lvl = ~lvl;
            run_left = $urandom_range(1, 12);
         end else begin
            run_left--;
         end
         raw = ($urandom_range(0, 15) == 0) ? ~lvl : lvl;

         // time advance scaled to the active period and debounce
         case ($urandom_range(0, 9))
            0: adv = 0;
            1: adv = 1;
            2, 3, 4: adv = $urandom_range(0, scale / 3);
            5, 6: adv = $urandom_range(scale / 2, scale + scale / 2);
            7: begin
               case ($urandom_range(0, 3))
                  0: adv = cfg_period;
                  1: adv = (cfg_period == 0) ? 0 : cfg_period - 1;
                  2: adv = cfg_debounce;
                  default: adv = cfg_debounce + 1;
               endcase
            end
            8: adv = $urandom_range(0, 4 * scale);
            default: adv = -1;
         endcase
         if (adv >= 0)
            sim_ms = sim_ms + adv;
         else if ($urandom_range(0, 1) == 0)
            sim_ms = 32'hFFFF_FFFF - $urandom_range(0, scale);
         else
            sim_ms = $urandom();

         pick = $urandom_range(0, 19);
         tgt  = $urandom_range(0, 7);
         if (pick <= 10)
            act = ACT_NONE;
         else if (pick <= 13)
            act = ACT_TOGGLE;
         else if (pick == 14)
            act = ACT_OFF;
         else if (pick <= 16)
            act = ACT_START;
         else if (pick == 17)
            act = ACT_STOP;
         else if (pick == 18)
            act = $urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI);
         else begin
            act = ACT_TOGGLE;
            tgt = $urandom_range(0, NUM_OUTPUTS - 1);
         end
         queue_poll(act, tgt, raw, sim_ms, (i == count / 2) || ($urandom_range(0, 63) == 0));
      end
   endtask

   // poll driver
   always @(posedge clock) begin : drv
      logic     fire;
      poll_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_wait  <= 0;
         accepted_cnt <= 0;
      end else begin
         fire = req_tvalid && req_tready;
         if (fire) begin
            predict_poll(live_poll);
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_tvalid || fire) begin
            if (poll_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (idle_wait < poll_q[0].gap) begin
               idle_wait  <= idle_wait + 1;
               req_tvalid <= 1'b0;
            end else if (poll_q[0].hold && (accepted_cnt + fire) != checked_cnt) begin
               req_tvalid <= 1'b0;
            end else begin
               nxt = poll_q.pop_front();
               live_poll  <= nxt;
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, nxt.now_ms, nxt.level, nxt.target};
               req_tuser  <= nxt.action;
               idle_wait  <= 0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : mon
      status_type want;
      logic       go;
      int         stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         go = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               log_fault($sformatf("unexpected result %02h", rsp_tdata));
            end else begin
               want = status_q.pop_front();
               if (rsp_tdata[2:0] !== want.on_mask)
                  log_fault($sformatf("on_mask exp %03b got %03b", want.on_mask,
                                      rsp_tdata[2:0]));
               if (rsp_tdata[3] !== want.commutating)
                  log_fault($sformatf("commutating exp %0b got %0b", want.commutating,
                                      rsp_tdata[3]));
            end
            checked_cnt <= checked_cnt + 1;
            if (checked_cnt % 50 == 0)
               ready_calm = ($urandom_range(0, 3) == 0);
            stall = ready_calm ? 0 : $urandom_range(0, 13);
            // ready stays low for the drawn stall, then rises again
            stall_left <= (stall > 0) ? stall - 1 : 0;
            go = (stall == 0);
         end else if (!rsp_tready) begin
            if (stall_left == 0)
               go = 1'b1;
            else
               stall_left <= stall_left - 1;
         end
         rsp_tready <= go;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stim
      cfg_period    = STEP_PERIOD_RST;
      cfg_debounce  = DEBOUNCE_RST;
      cfg_width     = WINDOW_RST;
      cfg_button    = BTN_TARGET_RST;
      mask_now      = '0;
      commutate_on  = 1'b0;
      window_head   = 0;
      last_step_ms  = '0;
      prev_level    = 1'b1;
      level_edge_ms = '0;
      settled_level = 1'b1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed polls at reset settings
      @(negedge clock);
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'd0,   1'b0);
      queue_poll(ACT_TOGGLE,     3'd0, 1'b1, 32'd1,   1'b0);
      queue_poll(ACT_TOGGLE,     3'd2, 1'b1, 32'd2,   1'b0);
      // out-of-range toggles
      queue_poll(ACT_TOGGLE,     3'd7, 1'b1, 32'd3,   1'b0);
      queue_poll(ACT_TOGGLE,     3'd3, 1'b1, 32'd4,   1'b0);
      // unknown codes do nothing
      queue_poll(ACT_UNKNOWN_LO, 3'd1, 1'b1, 32'd5,   1'b0);
      queue_poll(ACT_UNKNOWN_HI, 3'd1, 1'b1, 32'd6,   1'b0);
      queue_poll(ACT_OFF,        3'd0, 1'b1, 32'd7,   1'b0);
      // press: held past debounce toggles the button target
      queue_poll(ACT_NONE,       3'd0, 1'b0, 32'd10,  1'b0);
      queue_poll(ACT_NONE,       3'd0, 1'b0, 32'd61,  1'b0);
      // release: exactly at debounce is not enough, one more ms is
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'd70,  1'b0);
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'd120, 1'b0);
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'd121, 1'b0);
      // commutation with window wrap
      queue_poll(ACT_START,      3'd0, 1'b1, 32'd200, 1'b0);
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'd250, 1'b0);
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'd300, 1'b0);
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'd400, 1'b0);
      // stop keeps window start, restart steps at once
      queue_poll(ACT_STOP,       3'd0, 1'b1, 32'd500, 1'b0);
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'd700, 1'b0);
      queue_poll(ACT_START,      3'd0, 1'b1, 32'd701, 1'b0);
      // time wrap
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'hFFFF_FFF0, 1'b0);
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'h0000_0010, 1'b0);
      queue_poll(ACT_NONE,       3'd0, 1'b1, 32'h0000_0060, 1'b0);
      queue_poll(ACT_STOP,       3'd7, 1'b1, 32'hFFFF_FFFF, 1'b0);
      queue_poll(ACT_TOGGLE,     3'd6, 1'b0, 32'hAAAA_5555, 1'b0);
      sim_ms = 32'hAAAA_5555;
      wait_drained();

      // low extremes: zero width, every enabled poll steps
      write_regs(16'd0, 16'd0, 16'd0, 16'd0);
      fill_random(100);
      wait_drained();

      // high extremes: wide window, button target out of range
      write_regs(16'hFFFF, 16'hFFFF, 16'd3, 16'd3);
      fill_random(100);
      wait_drained();

      // random settings, upper data bits of the narrow registers random
      for (int ph = 0; ph < 6; ph++) begin
         write_regs($urandom_range(0, 300), $urandom_range(0, 120),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
         fill_random(100);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (status_q.size() != 0)
         log_fault($sformatf("%0d results never arrived", status_q.size()));
      if (fault_cnt == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/awc_pkg.sv
rtl/awc_cell.sv
rtl/actuator_window_commutator.sv
rtl/awc_checker.sv
verif/tb_actuator_window_commutator.sv
